// ----- sv/pnc_pkg.sv -----
package pnc_pkg;

    // Palette depth and the part of it that the 8-bit fields can reach.
    localparam int PAL_ENTRIES = 256;
    localparam int SCAN_LEN    = (PAL_ENTRIES < 256) ? PAL_ENTRIES : 256;
    localparam int ADDR_W      = (SCAN_LEN > 1) ? $clog2(SCAN_LEN) : 1;

    localparam int CHAN_W = 8;
    localparam int IDX_W  = 8;
    localparam int SQ_W   = 2 * CHAN_W;
    localparam int DIST_W = 18;
    localparam int RGB_W  = 3 * CHAN_W;

    localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

    // Request codes
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_NEAREST = 2'd1;
    localparam logic [1:0] REQ_PURE    = 2'd2;

    // Primary channel codes
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [IDX_W-1:0]  entry_index;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [1:0]        primary_select;
    } t_pnc_in;

    typedef struct packed {
        logic [IDX_W-1:0]  best_index;
        logic [DIST_W-1:0] best_distance;
        logic              found;
    } t_pnc_out;

    // Tag that travels alongside each palette read
    typedef struct packed {
        logic             vld;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_pnc_scan_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_pnc_state;

endpackage

// ----- sv/palette_nearest_colour_search.sv -----
// Palette write: no result; a new item is taken the next cycle.
// Query: the input stalls through the scan and the drain, and the next item is taken only once the result is loaded.
// The scan goes through the single read port of the palette memory, one entry per cycle
// over all 256 entries, then through a read, a square and a compare stage.
// Reset (i_rst_n low, synchronous) clears control and the output valid; the palette
// keeps no reset value and every entry must be written before the first query.
module palette_nearest_colour_search (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pnc_pkg::t_pnc_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output pnc_pkg::t_pnc_out o_out_data
);

    localparam logic [pnc_pkg::ADDR_W-1:0] LAST_ADDR = pnc_pkg::ADDR_W'(pnc_pkg::SCAN_LEN - 1);

    pnc_pkg::t_pnc_state           r_state, n_state;
    logic [pnc_pkg::ADDR_W-1:0]    r_cnt;
    pnc_pkg::t_pnc_in              r_query;
    pnc_pkg::t_pnc_scan_ctl        r_rd_ctl;
    logic                          r_out_valid;
    pnc_pkg::t_pnc_out             r_out;

    logic                          in_xfer;
    logic                          is_query;
    logic                          wr_en;
    logic                          rd_en;
    logic                          slot_free;
    logic                          load_out;
    logic [pnc_pkg::RGB_W-1:0]     ram_rdata;
    logic                          scan_done;
    pnc_pkg::t_pnc_out             scan_result;

    // Take items only while idle; the output register decouples the result side.
    assign in_xfer   = i_in_valid && !o_in_stall;
    assign is_query  = (i_in_data.req_type == pnc_pkg::REQ_NEAREST)
                    || (i_in_data.req_type == pnc_pkg::REQ_PURE);
    assign slot_free = !r_out_valid || !i_out_stall;

    // Next-state logic
    always_comb begin
        n_state = r_state;
        case (r_state)
            pnc_pkg::ST_IDLE: begin
                if (in_xfer && is_query) begin
                    n_state = pnc_pkg::ST_SCAN;
                end
            end
            pnc_pkg::ST_SCAN: begin
                if (r_cnt == LAST_ADDR) begin
                    n_state = pnc_pkg::ST_DRAIN;
                end
            end
            pnc_pkg::ST_DRAIN: begin
                // Wait for the last entry to clear the compare stage
                if (scan_done) begin
                    n_state = pnc_pkg::ST_DONE;
                end
            end
            pnc_pkg::ST_DONE: begin
                if (slot_free) begin
                    n_state = pnc_pkg::ST_IDLE;
                end
            end
            default: n_state = pnc_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_stall = 1'b1;
        rd_en      = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            pnc_pkg::ST_IDLE:  o_in_stall = 1'b0;
            pnc_pkg::ST_SCAN:  rd_en      = 1'b1;
            pnc_pkg::ST_DRAIN: o_in_stall = 1'b1;
            pnc_pkg::ST_DONE:  load_out   = slot_free;
            default:           o_in_stall = 1'b1;
        endcase
    end

    // Palette write straight from the input transfer; drop indexes past the palette.
    assign wr_en = in_xfer && (i_in_data.req_type == pnc_pkg::REQ_WRITE)
                && ({1'b0, i_in_data.entry_index} < 9'(pnc_pkg::SCAN_LEN));

    pnc_palette_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (pnc_pkg::ADDR_W'(i_in_data.entry_index)),
        .i_wdata ({i_in_data.red, i_in_data.green, i_in_data.blue}),
        .i_re    (rd_en),
        .i_raddr (r_cnt),
        .o_rdata (ram_rdata)
    );

    pnc_score u_score (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_query  (r_query),
        .i_ctl    (r_rd_ctl),
        .i_entry  (ram_rdata),
        .o_done   (scan_done),
        .o_result (scan_result)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pnc_pkg::ST_IDLE;
            r_cnt        <= '0;
            r_rd_ctl.vld <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rd_ctl.vld <= rd_en;
            // Tag follows the read so it lines up with the registered read data
            r_rd_ctl.first <= (r_cnt == '0);
            r_rd_ctl.last  <= (r_cnt == LAST_ADDR);
            r_rd_ctl.idx   <= pnc_pkg::IDX_W'(r_cnt);
            // Advance the scan address; restart from entry zero at the end
            if (rd_en) begin
                r_cnt <= (r_cnt == LAST_ADDR) ? '0 : r_cnt + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer && is_query) begin
            r_query <= i_in_data;
        end
        if (load_out) begin
            r_out <= scan_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- sv/pnc_palette_ram.sv -----
module pnc_palette_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [pnc_pkg::ADDR_W-1:0] i_waddr,
    input  logic [pnc_pkg::RGB_W-1:0]  i_wdata,
    input  logic                       i_re,
    input  logic [pnc_pkg::ADDR_W-1:0] i_raddr,
    output logic [pnc_pkg::RGB_W-1:0]  o_rdata
);

    logic [pnc_pkg::RGB_W-1:0] r_mem [pnc_pkg::SCAN_LEN];
    logic [pnc_pkg::RGB_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/pnc_score.sv -----
module pnc_score (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pnc_pkg::t_pnc_in          i_query,
    input  pnc_pkg::t_pnc_scan_ctl    i_ctl,
    input  logic [pnc_pkg::RGB_W-1:0] i_entry,
    output logic                      o_done,
    output pnc_pkg::t_pnc_out         o_result
);

    localparam int CW = pnc_pkg::CHAN_W;

    logic [CW-1:0] e_red, e_green, e_blue;
    logic [CW-1:0] d_red, d_green, d_blue;
    logic [CW-1:0] p_a, p_o1, p_o2, p_m;
    logic          p_qual;
    logic          nearest;

    // Stage 1 registers
    pnc_pkg::t_pnc_scan_ctl        r_s1_ctl;
    logic [pnc_pkg::SQ_W-1:0]      r_s1_sq_r, r_s1_sq_g, r_s1_sq_b;
    logic                          r_s1_qual;
    logic [CW-1:0]                 r_s1_score;

    // Running best
    logic                          r_have;
    logic [pnc_pkg::IDX_W-1:0]     r_best_idx;
    logic [pnc_pkg::DIST_W-1:0]    r_best_dist;
    logic                          r_done;

    logic [pnc_pkg::DIST_W-1:0]    cand;
    logic                          cand_ok;
    logic                          take;

    assign e_red   = i_entry[3*CW-1:2*CW];
    assign e_green = i_entry[2*CW-1:CW];
    assign e_blue  = i_entry[CW-1:0];
    assign nearest = (i_query.req_type == pnc_pkg::REQ_NEAREST);

    assign d_red   = (i_query.red > e_red) ? i_query.red - e_red : e_red - i_query.red;
    assign d_green = (i_query.green > e_green) ? i_query.green - e_green
                                               : e_green - i_query.green;
    assign d_blue  = (i_query.blue > e_blue) ? i_query.blue - e_blue : e_blue - i_query.blue;

    // Primary channel against the larger of the other two
    always_comb begin
        p_a  = e_red;
        p_o1 = e_green;
        p_o2 = e_blue;
        case (i_query.primary_select)
            pnc_pkg::CH_RED: begin
                p_a  = e_red;
                p_o1 = e_green;
                p_o2 = e_blue;
            end
            pnc_pkg::CH_GREEN: begin
                p_a  = e_green;
                p_o1 = e_blue;
                p_o2 = e_red;
            end
            pnc_pkg::CH_BLUE: begin
                p_a  = e_blue;
                p_o1 = e_red;
                p_o2 = e_green;
            end
            default: begin
                // No channel selected: nothing can qualify
                p_a  = '0;
                p_o1 = '1;
                p_o2 = '1;
            end
        endcase
        p_m    = (p_o1 > p_o2) ? p_o1 : p_o2;
        p_qual = (p_a > p_m);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl.vld <= 1'b0;
        end else begin
            r_s1_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_sq_r      <= pnc_pkg::SQ_W'(d_red) * pnc_pkg::SQ_W'(d_red);
        r_s1_sq_g      <= pnc_pkg::SQ_W'(d_green) * pnc_pkg::SQ_W'(d_green);
        r_s1_sq_b      <= pnc_pkg::SQ_W'(d_blue) * pnc_pkg::SQ_W'(d_blue);
        r_s1_qual      <= p_qual;
        r_s1_score     <= pnc_pkg::CHAN_MAX - (p_a - p_m);
    end

    // Stage 2: sum the squares (nearest) or take the pure score, and compare against the running best
    always_comb begin
        if (nearest) begin
            cand    = pnc_pkg::DIST_W'(r_s1_sq_r) + pnc_pkg::DIST_W'(r_s1_sq_g)
                    + pnc_pkg::DIST_W'(r_s1_sq_b);
            cand_ok = 1'b1;
        end else begin
            cand    = pnc_pkg::DIST_W'(r_s1_score);
            cand_ok = r_s1_qual;
        end
        take = cand_ok && (r_s1_ctl.first || !r_have || (cand < r_best_dist));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_s1_ctl.vld && r_s1_ctl.last;
            if (r_s1_ctl.vld) begin
                if (take) begin
                    r_have <= 1'b1;
                end else if (r_s1_ctl.first) begin
                    r_have <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_ctl.vld) begin
            if (take) begin
                r_best_idx  <= r_s1_ctl.idx;
                r_best_dist <= cand;
            end else if (r_s1_ctl.first) begin
                r_best_idx  <= '0;
                r_best_dist <= '0;
            end
        end
    end

    assign o_done                 = r_done;
    assign o_result.best_index    = r_best_idx;
    assign o_result.best_distance = r_best_dist;
    assign o_result.found         = r_have;

endmodule

// ----- test/tb.sv -----
module tb;

    // Codes the package leaves out: the ignored request and the unused channel select.
    localparam logic [1:0] REQ_IGNORED = 2'd3;
    localparam logic [1:0] CH_NONE     = 2'd3;

    // Cycles to keep watching after the last expected match. This covers a full query
    // scan and drain plus margin, so a spurious late result is still caught.
    localparam int DRAIN_CYCLES = 300;

    // How palette colours are drawn in each phase.
    typedef enum int {
        STYLE_WHITE,
        STYLE_RANDOM,
        STYLE_CLUSTER,
        STYLE_GREY
    } t_palette_style;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    pnc_pkg::t_pnc_in  in_data   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    pnc_pkg::t_pnc_out out_data;

    // Shadow copy of the palette and the matches still owed by the block.
    logic [pnc_pkg::RGB_W-1:0] shadow_palette [pnc_pkg::SCAN_LEN];
    pnc_pkg::t_pnc_out         expected_matches [$];
    pnc_pkg::t_pnc_out         want_match;

    // Colours that the clustered phase draws from, so ties and exact hits are common.
    logic [pnc_pkg::RGB_W-1:0] cluster_rgb [4];

    int burst_left  = 0;
    int stall_left  = 0;
    int quiet_left  = 0;
    int error_count = 0;
    int n_transfers = 0;
    int n_writes    = 0;
    int n_nearest   = 0;
    int n_pure      = 0;
    int n_ignored   = 0;
    int n_checked   = 0;
    int n_not_found = 0;

    palette_nearest_colour_search u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Pull one colour channel out of a packed palette entry.
    function automatic int channel_value(input logic [pnc_pkg::RGB_W-1:0] rgb,
                                         input logic [1:0] ch);
        case (ch)
            pnc_pkg::CH_RED:   return int'(rgb[23:16]);
            pnc_pkg::CH_GREEN: return int'(rgb[15:8]);
            default:           return int'(rgb[7:0]);
        endcase
    endfunction

    // Least squared RGB distance over the shadow palette; first index wins ties.
    function automatic pnc_pkg::t_pnc_out nearest_match(input pnc_pkg::t_pnc_in item);
        pnc_pkg::t_pnc_out res;
        int                best_d;
        int                d;
        int                dr;
        int                dg;
        int                db;
        res       = '0;
        res.found = 1'b1;
        best_d    = 0;
        for (int i = 0; i < pnc_pkg::SCAN_LEN; i++) begin
            dr = int'(item.red)   - channel_value(shadow_palette[i], pnc_pkg::CH_RED);
            dg = int'(item.green) - channel_value(shadow_palette[i], pnc_pkg::CH_GREEN);
            db = int'(item.blue)  - channel_value(shadow_palette[i], pnc_pkg::CH_BLUE);
            d  = dr * dr + dg * dg + db * db;
            if (i == 0 || d < best_d) begin
                best_d         = d;
                res.best_index = pnc_pkg::IDX_W'(i);
            end
        end
        res.best_distance = pnc_pkg::DIST_W'(best_d);
        return res;
    endfunction

    // Entry whose primary channel most exceeds the other two; score is 255 minus the
    // excess, least score and then first index wins. Nothing qualifying gives all zero.
    function automatic pnc_pkg::t_pnc_out pure_match(input logic [1:0] sel);
        pnc_pkg::t_pnc_out res;
        bit                have;
        int                best_s;
        int                pri;
        int                o1;
        int                o2;
        int                m;
        int                s;
        res    = '0;
        have   = 1'b0;
        best_s = 0;
        if (sel != CH_NONE) begin
            for (int i = 0; i < pnc_pkg::SCAN_LEN; i++) begin
                pri = channel_value(shadow_palette[i], sel);
                o1  = channel_value(shadow_palette[i], 2'((int'(sel) + 1) % 3));
                o2  = channel_value(shadow_palette[i], 2'((int'(sel) + 2) % 3));
                m   = (o1 > o2) ? o1 : o2;
                if (pri > m) begin
                    s = int'(pnc_pkg::CHAN_MAX) - (pri - m);
                    if (!have || s < best_s) begin
                        have           = 1'b1;
                        best_s         = s;
                        res.best_index = pnc_pkg::IDX_W'(i);
                    end
                end
            end
        end
        res.found = have;
        if (have) begin
            res.best_distance = pnc_pkg::DIST_W'(best_s);
        end
        return res;
    endfunction

    // Apply one accepted transfer to the shadow state and queue any match it owes.
    task automatic predict_transfer(input pnc_pkg::t_pnc_in item);
        n_transfers++;
        case (item.req_type)
            pnc_pkg::REQ_WRITE: begin
                n_writes++;
                if (int'(item.entry_index) < pnc_pkg::SCAN_LEN) begin
                    shadow_palette[item.entry_index] = {item.red, item.green, item.blue};
                end
            end
            pnc_pkg::REQ_NEAREST: begin
                n_nearest++;
                expected_matches.push_back(nearest_match(item));
            end
            pnc_pkg::REQ_PURE: begin
                n_pure++;
                expected_matches.push_back(pure_match(item.primary_select));
            end
            default: begin
                n_ignored++;
            end
        endcase
    endtask

    // Present one item, hold it until the transfer, then record it. Valid stays high
    // between items of a burst; drop it only when a gap follows.
    task automatic send_item(input pnc_pkg::t_pnc_in item);
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_transfer(item);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_valid <= 1'b0;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(100, 280)) @(posedge clk);
            end else begin
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            if ($urandom_range(0, 3) == 0) begin
                burst_left = $urandom_range(30, 80);
            end else begin
                burst_left = $urandom_range(0, 6);
            end
        end
    endtask

    function automatic pnc_pkg::t_pnc_in make_write(input logic [7:0] idx,
                                                    input logic [pnc_pkg::RGB_W-1:0] rgb);
        pnc_pkg::t_pnc_in item;
        item.req_type       = pnc_pkg::REQ_WRITE;
        item.entry_index    = idx;
        {item.red, item.green, item.blue} = rgb;
        item.primary_select = 2'($urandom);
        return item;
    endfunction

    function automatic pnc_pkg::t_pnc_in make_query(input logic [1:0] req,
                                                    input logic [pnc_pkg::RGB_W-1:0] rgb,
                                                    input logic [1:0] sel);
        pnc_pkg::t_pnc_in item;
        item.req_type       = req;
        item.entry_index    = 8'($urandom);
        {item.red, item.green, item.blue} = rgb;
        item.primary_select = sel;
        return item;
    endfunction

    // Grey with an occasional tint: one channel raised qualifies for a pure query,
    // two raised equally qualify for none.
    function automatic logic [pnc_pkg::RGB_W-1:0] tinted_grey();
        logic [pnc_pkg::CHAN_W-1:0] g;
        logic [pnc_pkg::CHAN_W-1:0] up;
        logic [pnc_pkg::RGB_W-1:0]  rgb;
        g   = 8'($urandom);
        up  = (g > 8'd215) ? pnc_pkg::CHAN_MAX : g + 8'($urandom_range(1, 40));
        rgb = {g, g, g};
        case ($urandom_range(0, 7))
            0: rgb[23:16] = up;
            1: rgb[15:8]  = up;
            2: rgb[7:0]   = up;
            3: begin
                rgb[23:16] = up;
                rgb[7:0]   = up;
            end
            default: ;
        endcase
        return rgb;
    endfunction

    function automatic logic [pnc_pkg::RGB_W-1:0] palette_colour(input t_palette_style style);
        case (style)
            STYLE_WHITE:   return '1;
            STYLE_RANDOM:  return pnc_pkg::RGB_W'($urandom);
            STYLE_CLUSTER: return cluster_rgb[$urandom_range(0, 3)];
            default: begin
                logic [pnc_pkg::CHAN_W-1:0] g;
                g = 8'($urandom);
                return {g, g, g};
            end
        endcase
    endfunction

    // Write every entry so no query ever scans an unwritten one.
    task automatic fill_palette(input t_palette_style style);
        for (int i = 0; i < pnc_pkg::SCAN_LEN; i++) begin
            send_item(make_write(8'(i), palette_colour(style)));
        end
    endtask

    function automatic pnc_pkg::t_pnc_in random_item(input t_palette_style style);
        int                        k;
        logic [1:0]                sel;
        logic [pnc_pkg::RGB_W-1:0] rgb;
        pnc_pkg::t_pnc_in          item;
        k   = $urandom_range(0, 19);
        sel = ($urandom_range(0, 9) == 0) ? CH_NONE : 2'($urandom_range(0, 2));
        if ($urandom_range(0, 1) == 0) begin
            rgb = (style == STYLE_GREY) ? tinted_grey() : palette_colour(style);
        end else begin
            rgb = pnc_pkg::RGB_W'($urandom);
        end
        if (k <= 6) begin
            if (style == STYLE_GREY) begin
                rgb = tinted_grey();
            end
            item = make_write(8'($urandom), rgb);
        end else if (k <= 12) begin
            item = make_query(pnc_pkg::REQ_NEAREST, rgb, sel);
        end else if (k <= 18) begin
            item = make_query(pnc_pkg::REQ_PURE, rgb, sel);
        end else begin
            item = make_query(REQ_IGNORED, pnc_pkg::RGB_W'($urandom), 2'($urandom));
        end
        return item;
    endfunction

    task automatic run_random(input t_palette_style style, input int count);
        for (int n = 0; n < count; n++) begin
            send_item(random_item(style));
        end
    endtask

    // All-white palette: every nearest query ties across the whole palette, the far
    // corner gives the largest distance and no pure query qualifies. Then plant
    // saturated entries to probe the pure scoring, its ties and the unused fields.
    task automatic test_extremes_and_ties();
        fill_palette(STYLE_WHITE);
        send_item(make_query(pnc_pkg::REQ_NEAREST, 24'h000000, pnc_pkg::CH_RED));
        send_item(make_query(pnc_pkg::REQ_NEAREST, 24'hFFFFFF, pnc_pkg::CH_BLUE));
        send_item(make_query(pnc_pkg::REQ_PURE, 24'h000000, pnc_pkg::CH_RED));
        send_item(make_query(pnc_pkg::REQ_PURE, 24'hFFFFFF, pnc_pkg::CH_GREEN));
        send_item(make_query(pnc_pkg::REQ_PURE, 24'h123456, pnc_pkg::CH_BLUE));
        send_item(make_query(pnc_pkg::REQ_PURE, 24'h123456, CH_NONE));
        send_item(make_query(REQ_IGNORED, 24'hFFFFFF, CH_NONE));
        send_item(make_write(8'd200, 24'hFF0000));
        send_item(make_write(8'd100, 24'hFE0000));
        send_item(make_query(pnc_pkg::REQ_PURE, 24'h000000, pnc_pkg::CH_RED));
        send_item(make_write(8'd50, 24'hFF0000));
        send_item(make_query(pnc_pkg::REQ_PURE, 24'hFFFFFF, pnc_pkg::CH_RED));
        send_item(make_write(8'd10, 24'h000100));
        send_item(make_query(pnc_pkg::REQ_PURE, 24'h000000, pnc_pkg::CH_GREEN));
        send_item(make_write(8'd255, 24'h0000FF));
        send_item(make_query(pnc_pkg::REQ_PURE, 24'h000000, pnc_pkg::CH_BLUE));
        send_item(make_write(8'd0, 24'h000000));
        send_item(make_query(pnc_pkg::REQ_NEAREST, 24'h000000, CH_NONE));
        send_item(make_query(pnc_pkg::REQ_NEAREST, 24'h010101, pnc_pkg::CH_RED));
        send_item(make_query(pnc_pkg::REQ_NEAREST, 24'hFF0000, pnc_pkg::CH_GREEN));
        send_item(make_query(pnc_pkg::REQ_PURE, 24'hFFFFFF, CH_NONE));
    endtask

    // Random colours written over the palette left by the previous phase.
    task automatic test_random_palette();
        run_random(STYLE_RANDOM, 45);
    endtask

    // Few distinct colours written in: exact hits and many equal distances.
    task automatic test_clustered_palette();
        for (int c = 0; c < 4; c++) begin
            cluster_rgb[c] = pnc_pkg::RGB_W'($urandom);
        end
        run_random(STYLE_CLUSTER, 40);
    endtask

    // Grey and tinted grey writes, so pure queries see entries that barely qualify.
    task automatic test_grey_palette();
        run_random(STYLE_GREY, 40);
    endtask

    // Check every result transfer against the oldest owed match, and drive the
    // receiver's own stall pattern: short stall runs between quiet stretches.
    always @(posedge clk) begin
        if (out_valid && !out_stall) begin
            if (expected_matches.size() == 0) begin
                $error("unexpected result: best_index %0d best_distance %0d found %0d",
                       out_data.best_index, out_data.best_distance, out_data.found);
                error_count++;
            end else begin
                want_match = expected_matches.pop_front();
                n_checked++;
                if (!want_match.found) begin
                    n_not_found++;
                end
                if (out_data.best_index !== want_match.best_index) begin
                    $error("best_index: expected %0d, actual %0d",
                           want_match.best_index, out_data.best_index);
                    error_count++;
                end
                if (out_data.best_distance !== want_match.best_distance) begin
                    $error("best_distance: expected %0d, actual %0d",
                           want_match.best_distance, out_data.best_distance);
                    error_count++;
                end
                if (out_data.found !== want_match.found) begin
                    $error("found: expected %0d, actual %0d",
                           want_match.found, out_data.found);
                    error_count++;
                end
            end
        end

        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (quiet_left > 0) begin
            quiet_left--;
            out_stall <= 1'b0;
        end else if ($urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(0, 11);
            out_stall <= 1'b1;
        end else begin
            quiet_left = ($urandom_range(0, 7) == 0) ? $urandom_range(300, 600)
                                                     : $urandom_range(0, 40);
            out_stall <= 1'b0;
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_extremes_and_ties();
        test_random_palette();
        test_clustered_palette();
        test_grey_palette();

        // Hold the input idle, collect the owed matches, then watch for strays.
        in_valid <= 1'b0;
        while (expected_matches.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d input transfers: %0d writes, %0d nearest, %0d pure, %0d ignored",
                 n_transfers, n_writes, n_nearest, n_pure, n_ignored);
        $display("Checked %0d results (%0d not found) over white, random, clustered and grey",
                 n_checked, n_not_found);
        if (error_count == 0 && expected_matches.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
